// ===== hw/rtl/atrs_pkg.sv =====
// Shared types, constants and helper functions for the truecolor run splitter.
package atrs_pkg;

    // Line and parameter limits.
    localparam int MAX_LINE    = 4096;
    localparam int POS_W       = $clog2(MAX_LINE) + 1;
    localparam int OFFSET_W    = 12;
    localparam int MAX_PARAMS  = 8;
    localparam int PV_DEPTH    = 5;
    localparam int PV_IDX_W    = $clog2(PV_DEPTH);
    localparam int PCNT_W      = $clog2(MAX_PARAMS + 1);
    localparam int ACC_W       = 12;
    localparam int ACC_MAX     = 4095;
    localparam int RESQ_DEPTH  = 4;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    // Byte codes recognized by the parser.
    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] CSI_OPEN    = 8'h5B;
    localparam logic [7:0] SGR_END     = 8'h6D;
    localparam logic [7:0] PARAM_SEP   = 8'h3B;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    // SGR parameter values of interest.
    localparam logic [ACC_W-1:0] SGR_TRUECOLOR = 12'd38;
    localparam logic [ACC_W-1:0] SGR_RGB_MODE  = 12'd2;
    localparam logic [ACC_W-1:0] SGR_RESET     = 12'd0;

    // Default color register reset values.
    localparam logic [7:0] DEF_RED_RST   = 8'd131;
    localparam logic [7:0] DEF_GREEN_RST = 8'd148;
    localparam logic [7:0] DEF_BLUE_RST  = 8'd150;

    // Parser mode.
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEF_RED   = 2'd0,
        CFG_DEF_GREEN = 2'd1,
        CFG_DEF_BLUE  = 2'd2
    } cfg_idx_t;

    // Gathered CSI parameters.
    typedef struct packed {
        logic [ACC_W-1:0]                acc;
        logic [PCNT_W-1:0]               cnt;
        logic [PV_DEPTH-1:0][ACC_W-1:0]  pv;
    } param_t;

    // One result item.
    typedef struct packed {
        logic [OFFSET_W-1:0] run_offset;
        logic [POS_W-1:0]    run_bytes;
        logic [7:0]          run_red;
        logic [7:0]          run_green;
        logic [7:0]          run_blue;
        logic                line_end;
        logic                overflow;
    } result_t;

    // Store the accumulator as the next parameter; extra parameters are dropped.
    function automatic param_t push_param(param_t p);
        param_t r;
        r = p;
        if (p.cnt < PCNT_W'(MAX_PARAMS))
        begin
            if (p.cnt < PCNT_W'(PV_DEPTH))
            begin
                r.pv[p.cnt[PV_IDX_W-1:0]] = p.acc;
            end
            r.cnt = p.cnt + 1'b1;
        end
        r.acc = '0;
        return r;
    endfunction

    // Line offset saturated to the offset field.
    function automatic logic [OFFSET_W-1:0] sat_offset(logic [POS_W-1:0] pos);
        logic [OFFSET_W-1:0] r;
        if (pos > POS_W'(ACC_MAX))
        begin
            r = '1;
        end
        else
        begin
            r = pos[OFFSET_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ansi_truecolor_run_splitter_core.sv =====
// Top level of the ANSI truecolor run splitter: parser state, run emission and result queue.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tdata: text_byte; tlast: line_last
//  m_*      | out       | m_tvalid/m_tready | tdata: run fields; tlast: line_end;
//           |           |                   | tuser: overflow
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (default color)
//
// One byte is taken per clock; the parser state updates in the cycle of the transaction.
// Each byte yields zero, one or two results, written into a four-entry result queue.
// Input is accepted while the queue holds two results or fewer, which leaves room for both
// results of a byte; with m_tready held high the queue never passes two, so rate is one byte
// per clock. Reset (rst_n low, asynchronous) returns the parser to text mode at offset zero,
// restores the default color registers and empties the result queue.
module ansi_truecolor_run_splitter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [11:0] run_offset, [24:12] run_bytes, [32:25] run_red,
                                    // [40:33] run_green, [48:41] run_blue, [55:49] zero
    output logic        m_tlast,
    output logic        m_tuser,    // [0] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int PW = atrs_pkg::POS_W;

    // Parser state.
    atrs_pkg::mode_t        mode_reg, mode_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [PW-1:0]          begin_reg, begin_next;
    logic                   is_def_reg, is_def_next;
    logic [7:0]             cur_red_reg, cur_red_next;
    logic [7:0]             cur_green_reg, cur_green_next;
    logic [7:0]             cur_blue_reg, cur_blue_next;
    atrs_pkg::param_t       prm_reg, prm_next;
    logic                   exc_reg, exc_next;

    // Default color registers.
    logic [7:0]             def_red_reg, def_green_reg, def_blue_reg;

    // Result queue.
    atrs_pkg::result_t      resq_reg [atrs_pkg::RESQ_DEPTH];
    logic [atrs_pkg::RESQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [atrs_pkg::RESQ_CNT_W-1:0] cnt_reg;

    // Intermediate values of the byte step.
    atrs_pkg::mode_t        mode_a;
    logic [PW-1:0]          pos_a, begin_a, esc_at, len_a;
    atrs_pkg::param_t       prm_a, prm_f;
    logic                   exc_a, fin, truecolor, to_default;
    logic                   e0_v;
    logic [PW-1:0]          e0_len;
    logic [15:0]            acc_prod;
    logic [atrs_pkg::ACC_W-1:0] acc_dig;
    logic                   is_esc, is_digit;
    logic [7:0]             b;
    logic                   last;
    atrs_pkg::result_t      res0, res1;
    logic                   s_fire, m_fire;
    logic [1:0]             n_push;

    assign b      = s_tdata;
    assign last   = s_tlast;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign is_esc = (b == atrs_pkg::ESC_BYTE) && !last;
    assign is_digit = b inside {[atrs_pkg::DIGIT_ZERO:atrs_pkg::DIGIT_NINE]};
    assign esc_at = pos_reg - 1'b1;

    // Decimal accumulator with saturation.
    assign acc_prod = {4'd0, prm_reg.acc} * 16'd10 + {12'd0, b[3:0]};
    assign acc_dig  = (acc_prod > 16'(atrs_pkg::ACC_MAX)) ? atrs_pkg::ACC_W'(atrs_pkg::ACC_MAX)
                                                          : acc_prod[atrs_pkg::ACC_W-1:0];

    // Per-byte parsing step.
    always_comb
    begin
        mode_a  = mode_reg;
        pos_a   = pos_reg;
        begin_a = begin_reg;
        prm_a   = prm_reg;
        exc_a   = exc_reg;
        fin     = 1'b0;
        e0_v    = 1'b0;
        e0_len  = '0;
        if (pos_reg >= PW'(atrs_pkg::MAX_LINE))
        begin
            exc_a = 1'b1;
        end
        else
        begin
            case (mode_reg)
                atrs_pkg::MODE_ESC:
                begin
                    if (b == atrs_pkg::CSI_OPEN)
                    begin
                        if (esc_at > begin_reg)
                        begin
                            e0_v   = 1'b1;
                            e0_len = esc_at - begin_reg;
                        end
                        mode_a    = atrs_pkg::MODE_CSI;
                        prm_a.acc = '0;
                        prm_a.cnt = '0;
                    end
                    else
                    begin
                        mode_a = is_esc ? atrs_pkg::MODE_ESC : atrs_pkg::MODE_TEXT;
                    end
                    pos_a = pos_reg + 1'b1;
                end
                atrs_pkg::MODE_CSI:
                begin
                    if (b == atrs_pkg::SGR_END)
                    begin
                        fin     = 1'b1;
                        mode_a  = atrs_pkg::MODE_TEXT;
                        begin_a = pos_reg + 1'b1;
                    end
                    else if (b < atrs_pkg::CTRL_LIMIT)
                    begin
                        // The control byte closes the sequence and counts as text.
                        fin     = 1'b1;
                        begin_a = pos_reg;
                        mode_a  = is_esc ? atrs_pkg::MODE_ESC : atrs_pkg::MODE_TEXT;
                    end
                    else if (is_digit)
                    begin
                        prm_a.acc = acc_dig;
                    end
                    else if (b == atrs_pkg::PARAM_SEP)
                    begin
                        prm_a = atrs_pkg::push_param(prm_reg);
                    end
                    pos_a = pos_reg + 1'b1;
                end
                default:
                begin
                    mode_a = is_esc ? atrs_pkg::MODE_ESC : atrs_pkg::MODE_TEXT;
                    pos_a  = pos_reg + 1'b1;
                end
            endcase
        end
        // A sequence cut by the line end is applied before the line closes.
        if (last && (mode_a == atrs_pkg::MODE_CSI))
        begin
            fin     = 1'b1;
            begin_a = pos_a;
        end
    end

    // Sequence completion: push the last parameter and decode the SGR code.
    assign prm_f      = atrs_pkg::push_param(prm_a);
    assign truecolor  = (prm_f.cnt >= atrs_pkg::PCNT_W'(atrs_pkg::PV_DEPTH))
                        && (prm_f.pv[0] == atrs_pkg::SGR_TRUECOLOR)
                        && (prm_f.pv[1] == atrs_pkg::SGR_RGB_MODE);
    assign to_default = (prm_f.cnt != '0) && (prm_f.pv[0] == atrs_pkg::SGR_RESET);
    assign len_a      = (pos_a > begin_a) ? (pos_a - begin_a) : '0;

    // Color after this step and the next parser state.
    always_comb
    begin
        is_def_next    = is_def_reg;
        cur_red_next   = cur_red_reg;
        cur_green_next = cur_green_reg;
        cur_blue_next  = cur_blue_reg;
        if (fin && truecolor)
        begin
            is_def_next    = 1'b0;
            cur_red_next   = prm_f.pv[2][7:0];
            cur_green_next = prm_f.pv[3][7:0];
            cur_blue_next  = prm_f.pv[4][7:0];
        end
        else if (fin && to_default)
        begin
            is_def_next = 1'b1;
        end
        if (fin && (mode_a == atrs_pkg::MODE_CSI))
        begin
            mode_next = atrs_pkg::MODE_TEXT;
        end
        else
        begin
            mode_next = mode_a;
        end
        pos_next   = pos_a;
        begin_next = begin_a;
        prm_next   = fin ? prm_f : prm_a;
        exc_next   = exc_a;
    end

    // Result built from the run closed by an ESC '[' (color before the sequence).
    always_comb
    begin
        res0.run_offset = atrs_pkg::sat_offset(begin_reg);
        res0.run_bytes  = e0_len;
        res0.run_red    = is_def_reg ? def_red_reg   : cur_red_reg;
        res0.run_green  = is_def_reg ? def_green_reg : cur_green_reg;
        res0.run_blue   = is_def_reg ? def_blue_reg  : cur_blue_reg;
        res0.line_end   = 1'b0;
        res0.overflow   = exc_reg;
    end

    // Result that closes the line (color after any sequence applied in this step).
    always_comb
    begin
        res1.run_offset = atrs_pkg::sat_offset(begin_a);
        res1.run_bytes  = len_a;
        res1.run_red    = is_def_next ? def_red_reg   : cur_red_next;
        res1.run_green  = is_def_next ? def_green_reg : cur_green_next;
        res1.run_blue   = is_def_next ? def_blue_reg  : cur_blue_next;
        res1.line_end   = 1'b1;
        res1.overflow   = exc_a;
    end

    // Parser control state and parameters; a line end returns everything to line start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= atrs_pkg::MODE_TEXT;
            pos_reg    <= '0;
            begin_reg  <= '0;
            is_def_reg <= 1'b1;
            prm_reg    <= '0;
            exc_reg    <= 1'b0;
        end
        else if (s_fire)
        begin
            if (last)
            begin
                mode_reg    <= atrs_pkg::MODE_TEXT;
                pos_reg     <= '0;
                begin_reg   <= '0;
                is_def_reg  <= 1'b1;
                prm_reg     <= '0;
                exc_reg     <= 1'b0;
            end
            else
            begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                begin_reg   <= begin_next;
                is_def_reg  <= is_def_next;
                prm_reg     <= prm_next;
                exc_reg     <= exc_next;
            end
        end
    end

    // Color payload; only read once a truecolor code has set it.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cur_red_reg   <= cur_red_next;
            cur_green_reg <= cur_green_next;
            cur_blue_reg  <= cur_blue_next;
        end
    end

    // Default color registers, written through the configuration channel.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_red_reg   <= atrs_pkg::DEF_RED_RST;
            def_green_reg <= atrs_pkg::DEF_GREEN_RST;
            def_blue_reg  <= atrs_pkg::DEF_BLUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                atrs_pkg::CFG_DEF_RED:   def_red_reg   <= cfg_data;
                atrs_pkg::CFG_DEF_GREEN: def_green_reg <= cfg_data;
                atrs_pkg::CFG_DEF_BLUE:  def_blue_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Result queue: up to two writes per transaction, one read per output transaction.
    assign n_push = s_fire ? ({1'b0, e0_v} + {1'b0, last}) : 2'd0;

    always_ff @(posedge clk)
    begin
        if (s_fire && e0_v)
        begin
            resq_reg[wr_ptr_reg] <= res0;
            if (last)
            begin
                resq_reg[wr_ptr_reg + 1'b1] <= res1;
            end
        end
        else if (s_fire && last)
        begin
            resq_reg[wr_ptr_reg] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + atrs_pkg::RESQ_PTR_W'(n_push);
            if (m_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + atrs_pkg::RESQ_CNT_W'(n_push)
                       - atrs_pkg::RESQ_CNT_W'(m_fire);
        end
    end

    // Room for two more results is required before a byte is taken.
    assign s_tready = (cnt_reg <= atrs_pkg::RESQ_CNT_W'(atrs_pkg::RESQ_DEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {7'd0,
                       resq_reg[rd_ptr_reg].run_blue,
                       resq_reg[rd_ptr_reg].run_green,
                       resq_reg[rd_ptr_reg].run_red,
                       resq_reg[rd_ptr_reg].run_bytes,
                       resq_reg[rd_ptr_reg].run_offset};
    assign m_tlast  = resq_reg[rd_ptr_reg].line_end;
    assign m_tuser  = resq_reg[rd_ptr_reg].overflow;

`ifndef NO_ASSERTIONS
    // Queue occupancy stays within its depth.
    a_resq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= atrs_pkg::RESQ_CNT_W'(atrs_pkg::RESQ_DEPTH))
        else $error("result queue over its depth");

    // Occupancy agrees with the pointer distance.
    a_resq_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[atrs_pkg::RESQ_PTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg))
        else $error("result queue count and pointers disagree");

    // The run start never passes the line position, which never passes the limit.
    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        (begin_reg <= pos_reg) && (pos_reg <= PW'(atrs_pkg::MAX_LINE)))
        else $error("line position out of order");

    // A byte that ends the line returns the parser to line start.
    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=>
            (pos_reg == '0) && (mode_reg == atrs_pkg::MODE_TEXT) && !exc_reg && is_def_reg)
        else $error("line state not cleared at line end");

    // Parameter count never exceeds the parameter limit.
    a_param_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        prm_reg.cnt <= atrs_pkg::PCNT_W'(atrs_pkg::MAX_PARAMS))
        else $error("parameter count over limit");
`endif

endmodule

// ===== tb/tb_ansi_truecolor_run_splitter_core.sv =====
// Self-checking testbench for the ANSI truecolor run splitter core.
`timescale 1ns / 100ps

module tb_ansi_truecolor_run_splitter_core;

    import atrs_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE_WAIT = 8;
    localparam int END_WAIT    = 20;

    // Clock, reset and block ports.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // Shared testbench state.
    result_t     expected_runs[$];
    logic [7:0]  line_bytes[$];
    int          error_count = 0;
    int          sent_count  = 0;
    int          idle_cycles = 0;
    bit          send_fast   = 1'b0;
    bit          recv_fast   = 1'b0;

    // Predictor state: parser and default colour as seen from outside.
    mode_t       mode;
    int unsigned pos;
    int unsigned run_start;
    bit          use_default;
    logic [7:0]  col_r;
    logic [7:0]  col_g;
    logic [7:0]  col_b;
    int unsigned acc;
    int unsigned nparams;
    int unsigned params[PV_DEPTH];
    bit          line_over;
    logic [7:0]  def_r = DEF_RED_RST;
    logic [7:0]  def_g = DEF_GREEN_RST;
    logic [7:0]  def_b = DEF_BLUE_RST;

    ansi_truecolor_run_splitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Mismatches are printed and counted here.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Queue one expected run with the colour in force right now.
    function automatic void expect_run(int unsigned off, int unsigned len, bit closes);
        result_t r;
        r.run_offset = (off > ACC_MAX) ? 12'hFFF : off[11:0];
        r.run_bytes  = len[12:0];
        r.run_red    = use_default ? def_r : col_r;
        r.run_green  = use_default ? def_g : col_g;
        r.run_blue   = use_default ? def_b : col_b;
        r.line_end   = closes;
        r.overflow   = line_over;
        expected_runs.push_back(r);
    endfunction

    function automatic void clear_params();
        acc     = 0;
        nparams = 0;
        foreach (params[i])
            params[i] = 0;
    endfunction

    function automatic void store_param();
        if (nparams < MAX_PARAMS)
        begin
            if (nparams < PV_DEPTH)
                params[nparams] = acc;
            nparams++;
        end
        acc = 0;
    endfunction

    // End of a CSI sequence: apply truecolor or the reset code.
    function automatic void close_sequence();
        store_param();
        if (nparams >= PV_DEPTH && params[0] == SGR_TRUECOLOR && params[1] == SGR_RGB_MODE)
        begin
            use_default = 1'b0;
            col_r = params[2][7:0];
            col_g = params[3][7:0];
            col_b = params[4][7:0];
        end
        else if (nparams >= 1 && params[0] == SGR_RESET)
        begin
            use_default = 1'b1;
        end
        mode = MODE_TEXT;
    endfunction

    // A byte counted as text; an ESC that is not the last byte may open a sequence.
    function automatic void take_text(logic [7:0] b, bit last);
        if (b == ESC_BYTE && !last)
            mode = MODE_ESC;
        pos++;
    endfunction

    function automatic void clear_line();
        mode        = MODE_TEXT;
        pos         = 0;
        run_start   = 0;
        use_default = 1'b1;
        col_r       = '0;
        col_g       = '0;
        col_b       = '0;
        line_over   = 1'b0;
        clear_params();
    endfunction

    // Work out the runs that one accepted byte closes.
    function automatic void predict_runs(logic [7:0] b, bit last);
        int unsigned esc_at;
        int unsigned len;
        int unsigned v;
        if (pos >= MAX_LINE)
        begin
            line_over = 1'b1;
        end
        else if (mode == MODE_ESC)
        begin
            if (b == CSI_OPEN)
            begin
                esc_at = pos - 1;
                if (esc_at > run_start)
                    expect_run(run_start, esc_at - run_start, 1'b0);
                mode = MODE_CSI;
                clear_params();
                pos++;
            end
            else
            begin
                mode = MODE_TEXT;
                take_text(b, last);
            end
        end
        else if (mode == MODE_CSI)
        begin
            if (b == SGR_END)
            begin
                close_sequence();
                pos++;
                run_start = pos;
            end
            else if (b < CTRL_LIMIT)
            begin
                close_sequence();
                run_start = pos;
                take_text(b, last);
            end
            else
            begin
                if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                begin
                    v   = acc * 10 + int'(b - DIGIT_ZERO);
                    acc = (v > ACC_MAX) ? ACC_MAX : v;
                end
                else if (b == PARAM_SEP)
                begin
                    store_param();
                end
                pos++;
            end
        end
        else
        begin
            take_text(b, last);
        end

        // Line closure, applying a sequence cut short by the line end.
        if (last)
        begin
            if (mode == MODE_CSI)
            begin
                close_sequence();
                run_start = pos;
            end
            len = (pos > run_start) ? pos - run_start : 0;
            expect_run(run_start, len, 1'b1);
            clear_line();
        end
    endfunction

    // Send one byte after a random gap (none when send_fast is set) and predict its runs on acceptance.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_runs(b, last);
        sent_count++;
    endtask

    // Send the assembled line, marking its final byte.
    task automatic send_line();
        int n;
        n = line_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(line_bytes[i], i == n - 1);
        line_bytes.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    // Hold the input until every expected run has come, then let the block settle.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEF_RED:   def_r = value;
            CFG_DEF_GREEN: def_g = value;
            CFG_DEF_BLUE:  def_b = value;
            default:       ;
        endcase
    endtask

    task automatic set_defaults(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        wait_drain();
        write_reg(CFG_DEF_RED, r);
        write_reg(CFG_DEF_GREEN, g);
        write_reg(CFG_DEF_BLUE, b);
        cfg_valid <= 1'b0;
    endtask

    // Parameter values: mostly colour bytes, some large ones and the key codes.
    function automatic int unsigned pick_value();
        int unsigned v;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = $urandom_range(256, 4095);
            2:       v = $urandom_range(4096, 99999);
            3:       v = $urandom_range(0, 1) ? SGR_TRUECOLOR : SGR_RGB_MODE;
            default: v = $urandom_range(0, 255);
        endcase
        return v;
    endfunction

    // Append one random piece of a line: text, a sequence, or noise.
    function automatic void add_segment();
        string alphabet;
        int    n;
        alphabet = "0123456789;;;;m: ?x";
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    line_bytes.push_back(8'($urandom_range(32, 126)));
            end
            3, 4:
            begin
                add_text($sformatf("%c[38;2;%0d;%0d;%0dm", ESC_BYTE,
                                   pick_value(), pick_value(), pick_value()));
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:       add_text($sformatf("%c[0m", ESC_BYTE));
                    1:       add_text($sformatf("%c[m", ESC_BYTE));
                    default: add_text($sformatf("%c[0;38;2;1;1;1m", ESC_BYTE));
                endcase
            end
            6:
            begin
                // Sequence with random content and a random ending, or none at all.
                line_bytes.push_back(ESC_BYTE);
                line_bytes.push_back(CSI_OPEN);
                n = $urandom_range(0, 10);
                repeat (n)
                    line_bytes.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
                case ($urandom_range(0, 2))
                    0:       line_bytes.push_back(SGR_END);
                    1:       line_bytes.push_back(8'($urandom_range(0, 31)));
                    default: ;
                endcase
            end
            7:
            begin
                line_bytes.push_back(ESC_BYTE);
            end
            8:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       add_text($sformatf("%c[38;5;%0dm", ESC_BYTE, pick_value()));
                    1:       add_text($sformatf("%c[38;2;%0d;%0dm", ESC_BYTE,
                                                pick_value(), pick_value()));
                    default: add_text($sformatf("%c[38;2;%0d;%0d;%0d;4;5;6;7;8m", ESC_BYTE,
                                                pick_value(), pick_value(), pick_value()));
                endcase
            end
        endcase
    endfunction

    // Extremes of the byte field, truecolor, reset code, lone and trailing ESC.
    task automatic test_directed_escapes();
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        add_text("\033[38;2;4095;256;511mAB\033[0;7mC\033");
        send_line();
        // Lone ESC, ESC ESC '[', large number, ignored byte, control byte ends it.
        add_text("\033X\033\033[99999x;2\001yz");
        send_line();
        // Parameters beyond the limit are dropped.
        add_text("\033[38;2;5;6;7;8;9;1;2mk");
        send_line();
        // Sequence cut by the line end, with an empty leading run.
        add_text("\033[");
        send_line();
        add_text("q");
        send_line();
    endtask

    // Several default colours, the extremes among them.
    task automatic test_default_colours();
        logic [7:0] settings[4][3];
        settings = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                     '{8'($urandom), 8'($urandom), 8'($urandom)},
                     '{DEF_RED_RST, DEF_GREEN_RST, DEF_BLUE_RST}};
        foreach (settings[i])
        begin
            set_defaults(settings[i][0], settings[i][1], settings[i][2]);
            add_text("pq\033[38;2;9;8;7mrs\033[mtu");
            send_line();
        end
    endtask

    // Lines at and past the maximum length, with offset saturation on closure.
    task automatic test_long_lines();
        send_fast = 1'b1;
        repeat (MAX_LINE - 4)
            line_bytes.push_back(8'($urandom_range(32, 126)));
        add_text("\033[0m!");
        send_line();
        send_fast = 1'b0;
        repeat (MAX_LINE)
            line_bytes.push_back(8'($urandom_range(32, 126)));
        send_line();
        add_text("\033[38;2;200;100;50m");
        repeat (MAX_LINE - line_bytes.size() + 4)
            line_bytes.push_back(8'($urandom_range(32, 126)));
        send_line();
        wait_drain();
    endtask

    // Random lines built mostly from well-formed pieces.
    task automatic test_random_lines();
        int target;
        int nseg;
        target = sent_count + 1150;
        while (sent_count < target)
        begin
            send_fast = ($urandom_range(0, 3) == 0);
            recv_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       set_defaults(8'd0, 8'd255, 8'd0);
                    1:       set_defaults(8'd255, 8'd0, 8'd255);
                    default: set_defaults(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            nseg = $urandom_range(1, 6);
            repeat (nseg)
                add_segment();
            if ($urandom_range(0, 7) == 0)
                line_bytes.push_back(ESC_BYTE);
            send_line();
        end
        send_fast = 1'b0;
        recv_fast = 1'b0;
    endtask

    // Main sequence: reset, then the tests in turn, then the verdict.
    initial
    begin
        clear_line();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_escapes();
        test_default_colours();
        test_long_lines();
        test_random_lines();
        wait_drain();
        repeat (END_WAIT) @(posedge clk);
        if (expected_runs.size() != 0)
            report_mismatch($sformatf("%0d expected runs never came", expected_runs.size()));
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls (none when recv_fast is set), each transaction compared with the oldest expectation.
    initial
    begin : check_results
        result_t exp_r;
        int      stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = recv_fast ? 0 : $urandom_range(0, 10);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (expected_runs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected run offset %0d bytes %0d",
                                          m_tdata[11:0], m_tdata[24:12]));
            end
            else
            begin
                exp_r = expected_runs.pop_front();
                if (m_tdata[11:0] !== exp_r.run_offset)
                    report_mismatch($sformatf("run_offset got %0d expected %0d",
                                              m_tdata[11:0], exp_r.run_offset));
                if (m_tdata[24:12] !== exp_r.run_bytes)
                    report_mismatch($sformatf("run_bytes got %0d expected %0d",
                                              m_tdata[24:12], exp_r.run_bytes));
                if (m_tdata[32:25] !== exp_r.run_red)
                    report_mismatch($sformatf("run_red got %0d expected %0d",
                                              m_tdata[32:25], exp_r.run_red));
                if (m_tdata[40:33] !== exp_r.run_green)
                    report_mismatch($sformatf("run_green got %0d expected %0d",
                                              m_tdata[40:33], exp_r.run_green));
                if (m_tdata[48:41] !== exp_r.run_blue)
                    report_mismatch($sformatf("run_blue got %0d expected %0d",
                                              m_tdata[48:41], exp_r.run_blue));
                if (m_tlast !== exp_r.line_end)
                    report_mismatch($sformatf("line_end got %0b expected %0b",
                                              m_tlast, exp_r.line_end));
                if (m_tuser !== exp_r.overflow)
                    report_mismatch($sformatf("overflow got %0b expected %0b",
                                              m_tuser, exp_r.overflow));
            end
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
